>>> design/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared types, constants and helpers for the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int MAX_CELLS_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DIR_FRAC = 16;
    localparam int DIR_W    = 18;
    localparam int ORG_W    = 32;
    localparam int T_W      = 32;
    localparam int CELL_W   = 16;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] VOXEL_COUNT_RST = 7'd64;
    localparam logic [T_W-1:0]   T_SAT           = '1;

    // Code for how a cell was reached.
    typedef enum logic [1:0] {
        MV_START = 2'd0,
        MV_X     = 2'd1,
        MV_Y     = 2'd2,
        MV_Z     = 2'd3
    } t_move;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // Step direction per axis, two's complement -1/0/+1.
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] a,
                                               input logic [T_W-1:0] b);
        logic [T_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[T_W] ? T_SAT : s[T_W-1:0];
    endfunction

endpackage

>>> design/vrt_div.sv
// ----------------------------------------------------------------------------
// vrt_div
// Shared restoring divider, one quotient bit per cycle, saturated 32-bit result.
// ----------------------------------------------------------------------------
module vrt_div import vrt_pkg::*; #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [T_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_nq;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W-1:0] n_rem;
    logic [63:0]      q_wide;

    always_comb begin
        rem_sh = {r_rem, r_nq[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        q_wide = 64'(r_nq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = (|q_wide[63:32]) ? T_SAT : q_wide[31:0];

endmodule

>>> design/voxel_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top
// 3D grid traversal of one fixed-point ray, emitting each visited cell.
// ----------------------------------------------------------------------------
//
// Channel    Direction  Contents
// s_axis     in         one ray: origin x/y/z and direction x/y/z
// m_axis     out        one visited cell per transaction, tlast on the final cell
// i_cfg_wr   in         voxel_count, the number of cells emitted per ray
//
// A ray transaction is taken only while the block is idle. Setup runs six jobs
// through the shared divider (next boundary time and boundary spacing for
// each axis); a job on an axis with zero direction skips the divider and takes
// a saturated time. The cells then leave at one per cycle. Output stalls hold
// the traversal in place, and a new ray is accepted while the previous ray's
// final cell still waits in the output register.
// Reset is synchronous and active low; it clears the control state and sets
// voxel_count to 64.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top import vrt_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write: voxel_count.
    input  logic              i_cfg_wr_en,
    input  logic [CFG_W-1:0]  i_cfg_wr_data,
    // Ray input.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: origin_x[31:0], origin_y[31:0], origin_z[31:0],
    // dir_x[17:0], dir_y[17:0], dir_z[17:0], two zero pad bits.
    input  logic [151:0]      s_axis_tdata,
    // Cell output.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // tdata from bit 0: cell_x[15:0], cell_y[15:0], cell_z[15:0].
    output logic [47:0]       m_axis_tdata,
    // tuser from bit 0: moved_axis[1:0].
    output logic [1:0]        m_axis_tuser,
    // tlast: last_cell.
    output logic              m_axis_tlast
);

    // The numerator of a division is a distance or one cell, shifted up by the
    // direction's fraction bits; one extra bit holds a full cell.
    localparam int NUM_W = FRAC_BITS + DIR_FRAC + 1;
    localparam int CNT_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [NUM_W-1:0] SPC_NUM = NUM_W'(1) << (FRAC_BITS + DIR_FRAC);
    localparam logic [FRAC_BITS:0] ONE_CELL = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // Input unpacking and per-axis setup values.
    logic [ORG_W-1:0]     in_org   [3];
    logic [DIR_W-1:0]     in_dir   [3];
    logic [CELL_W-1:0]    set_cell [3];
    logic [1:0]           set_sign [3];
    logic [DIR_W-1:0]     set_mag  [3];
    logic [FRAC_BITS:0]   set_dist [3];
    logic signed [ORG_W-1:0] int_part;

    assign in_org[0] = s_axis_tdata[31:0];
    assign in_org[1] = s_axis_tdata[63:32];
    assign in_org[2] = s_axis_tdata[95:64];
    assign in_dir[0] = s_axis_tdata[113:96];
    assign in_dir[1] = s_axis_tdata[131:114];
    assign in_dir[2] = s_axis_tdata[149:132];

    // The cell is the floor of the origin, kept at 16 bits. A negative
    // direction measures back to the cell's lower face, a positive one
    // forward to its upper face.
    always_comb begin
        int_part = '0;
        for (int i = 0; i < 3; i++) begin
            int_part    = $signed(in_org[i]) >>> FRAC_BITS;
            set_cell[i] = int_part[CELL_W-1:0];
            set_mag[i]  = in_dir[i][DIR_W-1] ? DIR_W'(-in_dir[i]) : in_dir[i];
            set_dist[i] = in_dir[i][DIR_W-1] ? {1'b0, in_org[i][FRAC_BITS-1:0]}
                                             : ONE_CELL - {1'b0, in_org[i][FRAC_BITS-1:0]};
            if (set_mag[i] == '0) begin
                set_sign[i] = SIGN_ZERO;
            end else if (in_dir[i][DIR_W-1]) begin
                set_sign[i] = SIGN_NEG;
            end else begin
                set_sign[i] = SIGN_POS;
            end
        end
    end

    // State.
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_vcount;
    logic [CELL_W-1:0]  r_cell [3];
    logic [1:0]         r_sign [3];
    logic [DIR_W-1:0]   r_mag  [3];
    logic [FRAC_BITS:0] r_dist [3];
    logic [T_W-1:0]     r_bnd  [3];
    logic [T_W-1:0]     r_spc  [3];
    logic [CNT_W-1:0]   r_left;
    logic               r_first;
    logic [1:0]         r_axis;
    logic               r_kind;   // 0: next boundary time, 1: boundary spacing
    logic               r_out_valid;
    logic [47:0]        r_out_data;
    t_move              r_out_move;
    logic               r_out_last;

    // Run length clamped to 1..MAX_CELLS.
    logic [CFG_W-1:0]   run_len;
    logic [CNT_W-1:0]   run_left;

    always_comb begin
        if (r_vcount == '0) begin
            run_len = CFG_W'(1);
        end else if (int'(r_vcount) > MAX_CELLS) begin
            run_len = CFG_W'(MAX_CELLS);
        end else begin
            run_len = r_vcount;
        end
        run_left = CNT_W'(run_len - CFG_W'(1));
    end

    // Divider job selection.
    logic [DIR_W-1:0]   job_mag;
    logic [FRAC_BITS:0] job_dist;
    logic [NUM_W-1:0]   job_num;
    logic               job_zero;
    logic               job_last;
    logic               job_wr;
    logic [T_W-1:0]     job_res;
    logic               div_start;
    logic               div_done;
    logic [T_W-1:0]     div_quot;

    always_comb begin
        case (r_axis)
            2'd0: begin
                job_mag  = r_mag[0];
                job_dist = r_dist[0];
            end
            2'd1: begin
                job_mag  = r_mag[1];
                job_dist = r_dist[1];
            end
            default: begin
                job_mag  = r_mag[2];
                job_dist = r_dist[2];
            end
        endcase
        job_num  = r_kind ? SPC_NUM : {job_dist, {DIR_FRAC{1'b0}}};
        job_zero = job_mag == '0;
        job_last = (r_axis == 2'd2) && r_kind;
        job_res  = job_zero ? T_SAT : div_quot;
    end

    vrt_div #(
        .NUM_W (NUM_W),
        .DEN_W (DIR_W)
    ) u_vrt_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (job_num),
        .i_den   (job_mag),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Stepping: the axis with the strictly smallest boundary time advances;
    // ties go to y over x and to z otherwise.
    logic [1:0]        step_ax;
    t_move             step_move;
    logic [T_W-1:0]    sel_bnd, sel_spc, new_bnd;
    logic [CELL_W-1:0] sel_cell, new_cell;
    logic [1:0]        sel_sign;
    logic [CELL_W-1:0] out_cell [3];
    logic              emit_ok;
    logic              emit_last;

    always_comb begin
        if (r_bnd[0] < r_bnd[1] && r_bnd[0] < r_bnd[2]) begin
            step_ax = 2'd0;
        end else if (r_bnd[1] < r_bnd[2]) begin
            step_ax = 2'd1;
        end else begin
            step_ax = 2'd2;
        end
        case (step_ax)
            2'd0: begin
                sel_bnd   = r_bnd[0];
                sel_spc   = r_spc[0];
                sel_cell  = r_cell[0];
                sel_sign  = r_sign[0];
                step_move = MV_X;
            end
            2'd1: begin
                sel_bnd   = r_bnd[1];
                sel_spc   = r_spc[1];
                sel_cell  = r_cell[1];
                sel_sign  = r_sign[1];
                step_move = MV_Y;
            end
            default: begin
                sel_bnd   = r_bnd[2];
                sel_spc   = r_spc[2];
                sel_cell  = r_cell[2];
                sel_sign  = r_sign[2];
                step_move = MV_Z;
            end
        endcase
        new_bnd = sat_add(sel_bnd, sel_spc);
        case (sel_sign)
            SIGN_POS: new_cell = sel_cell + CELL_W'(1);
            SIGN_NEG: new_cell = sel_cell - CELL_W'(1);
            default:  new_cell = sel_cell;
        endcase
        for (int i = 0; i < 3; i++) begin
            out_cell[i] = (!r_first && step_ax == 2'(i)) ? new_cell : r_cell[i];
        end
        emit_last = r_first ? (r_left == '0) : (r_left == CNT_W'(1));
    end

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        job_wr        = 1'b0;
        emit_ok       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (job_zero) begin
                    job_wr  = 1'b1;
                    n_state = job_last ? ST_EMIT : ST_LOAD;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    job_wr  = 1'b1;
                    n_state = job_last ? ST_EMIT : ST_LOAD;
                end
            end
            ST_EMIT: begin
                emit_ok = !r_out_valid || m_axis_tready;
                if (emit_ok && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_vcount    <= VOXEL_COUNT_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            if (emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            for (int i = 0; i < 3; i++) begin
                r_cell[i] <= set_cell[i];
                r_sign[i] <= set_sign[i];
                r_mag[i]  <= set_mag[i];
                r_dist[i] <= set_dist[i];
            end
            r_left  <= run_left;
            r_first <= 1'b1;
            r_axis  <= 2'd0;
            r_kind  <= 1'b0;
        end
        if (job_wr) begin
            for (int i = 0; i < 3; i++) begin
                if (r_axis == 2'(i)) begin
                    if (r_kind) begin
                        r_spc[i] <= job_res;
                    end else begin
                        r_bnd[i] <= job_res;
                    end
                end
            end
            r_kind <= ~r_kind;
            if (r_kind) begin
                r_axis <= r_axis + 2'd1;
            end
        end
        if (emit_ok) begin
            if (r_first) begin
                r_first    <= 1'b0;
                r_out_move <= MV_START;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_cell[i] <= out_cell[i];
                    if (step_ax == 2'(i)) begin
                        r_bnd[i] <= new_bnd;
                    end
                end
                r_left     <= r_left - CNT_W'(1);
                r_out_move <= step_move;
            end
            r_out_data <= {out_cell[2], out_cell[1], out_cell[0]};
            r_out_last <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_move;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> design/vrt_checker.sv
// ----------------------------------------------------------------------------
// vrt_checker
// Port-level checks for the voxel ray traversal block, bound to its top level.
// ----------------------------------------------------------------------------
module vrt_checker import vrt_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    logic s_fire;
    logic m_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    // A stalled cell transaction holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled cell transaction changed");

    // Setup starts right after a ray is taken, so the next one must wait.
    a_busy_after_ray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> !s_axis_tready)
        else $error("ray accepted while setup runs");

    // While a run is still open no new ray may enter.
    a_no_ray_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("ray accepted in the middle of a run");

    // A step along x leaves y and z of the previous cell untouched.
    a_x_step_only_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_fire && $past(m_fire) && m_axis_tuser == MV_X |->
            m_axis_tdata[47:16] == $past(m_axis_tdata[47:16]))
        else $error("x step changed y or z");

endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
